// ===== hdl/stt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	// scan mode, one-hot
	typedef enum logic [7:0] {
		MODE_IDLE    = 8'b0000_0001,
		MODE_IDENT   = 8'b0000_0010,
		MODE_NUM     = 8'b0000_0100,
		MODE_COMMENT = 8'b0000_1000,
		MODE_MINUS   = 8'b0001_0000,
		MODE_EQ      = 8'b0010_0000,
		MODE_BANG    = 8'b0100_0000,
		MODE_ERROR   = 8'b1000_0000
	} mode_t;

	// token kinds
	localparam logic [4:0] KIND_NUM    = 5'd0;
	localparam logic [4:0] KIND_IDENT  = 5'd1;
	localparam logic [4:0] KIND_SEMI   = 5'd2;
	localparam logic [4:0] KIND_LPAREN = 5'd3;
	localparam logic [4:0] KIND_RPAREN = 5'd4;
	localparam logic [4:0] KIND_LBRACE = 5'd5;
	localparam logic [4:0] KIND_RBRACE = 5'd6;
	localparam logic [4:0] KIND_BINOP  = 5'd7;
	localparam logic [4:0] KIND_ARROW  = 5'd8;
	localparam logic [4:0] KIND_COMMA  = 5'd9;
	localparam logic [4:0] KIND_ASSIGN = 5'd10;
	localparam logic [4:0] KIND_FN     = 5'd11;
	localparam logic [4:0] KIND_MUT    = 5'd12;
	localparam logic [4:0] KIND_IF     = 5'd13;
	localparam logic [4:0] KIND_ELSE   = 5'd14;
	localparam logic [4:0] KIND_ELIF   = 5'd15;
	localparam logic [4:0] KIND_CCND   = 5'd16;

	// binop operator codes
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_PLUS  = 4'd1;
	localparam logic [3:0] OP_MINUS = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_DIV   = 4'd4;
	localparam logic [3:0] OP_DOT   = 4'd5;
	localparam logic [3:0] OP_EQ    = 4'd6;
	localparam logic [3:0] OP_NE    = 4'd7;
	localparam logic [3:0] OP_PIPE  = 4'd8;

	// action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// status codes
	localparam logic ST_TOKEN = 1'b0;
	localparam logic ST_ERROR = 1'b1;

	// characters
	localparam logic [7:0] CH_NL      = 8'd10;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_GREATER = 8'h3E;

	// keyword spellings as they sit in the keyword window
	localparam logic [39:0] KW_FN   = 40'h00_0000_666E;
	localparam logic [39:0] KW_IF   = 40'h00_0000_6966;
	localparam logic [39:0] KW_MUT  = 40'h00_006D_7574;
	localparam logic [39:0] KW_ELSE = 40'h00_656C_7365;
	localparam logic [39:0] KW_ELIF = 40'h00_656C_6966;
	localparam logic [39:0] KW_CCND = 40'h00_6363_6E64;

	localparam logic [2:0] WLEN_MAX = 3'd5;

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;
	localparam int RQ_CNT_W = 3;

	typedef struct packed {
		logic       hit;
		logic [4:0] kind;
		logic [3:0] op;
	} sign_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	// complete single-character signs
	function automatic sign_t sign_of(input logic [7:0] c);
		sign_t s;
		s = '{hit: 1'b1, kind: KIND_BINOP, op: OP_NONE};
		unique case (c)
			8'h3B: s.kind = KIND_SEMI;
			8'h28: s.kind = KIND_LPAREN;
			8'h29: s.kind = KIND_RPAREN;
			8'h7B: s.kind = KIND_LBRACE;
			8'h7D: s.kind = KIND_RBRACE;
			8'h2B: s.op = OP_PLUS;
			8'h2A: s.op = OP_MUL;
			8'h2F: s.op = OP_DIV;
			8'h2E: s.op = OP_DOT;
			8'h7C: s.op = OP_PIPE;
			8'h2C: s.kind = KIND_COMMA;
			default: begin
				s.hit  = 1'b0;
				s.kind = KIND_NUM;
			end
		endcase
		return s;
	endfunction

	function automatic logic [4:0] word_kind(input logic [39:0] w, input logic [2:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		unique case (len)
			3'd2: begin
				if (w == KW_FN) k = KIND_FN;
				else if (w == KW_IF) k = KIND_IF;
			end
			3'd3: begin
				if (w == KW_MUT) k = KIND_MUT;
			end
			3'd4: begin
				if (w == KW_ELSE) k = KIND_ELSE;
				else if (w == KW_ELIF) k = KIND_ELIF;
				else if (w == KW_CCND) k = KIND_CCND;
			end
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/source_text_tokenizer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Character-stream tokenizer: emits kind, operator, line and columns per token.
// ----------------------------------------------------------------------------
// usage:
//   src channel (src_valid/src_stall) carries one character or an end-of-text
//   marker per transaction. tok channel (tok_valid/tok_stall) carries tokens
//   and error reports, last_of_run marking the final result of a character.
//   the scanner takes one character per cycle while src is not stalled; its
//   mode, counters and the five-byte keyword window update in that same cycle.
//   a result is written into the registered queue as its character is taken.
//   results wait in a four-entry queue; src is stalled while fewer than two
//   slots are free, so a stalled tok side backs up into src once three
//   results are waiting. when tok never stalls, src accepts a character
//   every cycle until characters that produce two results have built up
//   three waiting results; it then stalls while three results wait.
//   after an unknown byte or a lone '!' an error result is sent and further
//   characters are swallowed until end of text.
//   reset: scanner idle, line 1, column 0, queue empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   src_valid,
	output logic                        src_stall,
	input  wire logic                   action,
	input  wire logic [7:0]             char_code,
	output logic                        tok_valid,
	input  wire logic                   tok_stall,
	output logic                        status,
	output logic      [4:0]             token_kind,
	output logic      [3:0]             operator_code,
	output logic      [LINE_BITS-1:0]   line_number,
	output logic      [COLUMN_BITS-1:0] start_column,
	output logic      [COLUMN_BITS-1:0] end_column,
	output logic                        last_of_run
);

	localparam int ENTRY_W = 11 + LINE_BITS + 2 * COLUMN_BITS;
	localparam int E_LO    = 1;
	localparam int S_LO    = E_LO + COLUMN_BITS;
	localparam int L_LO    = S_LO + COLUMN_BITS;
	localparam int OP_LO   = L_LO + LINE_BITS;
	localparam int K_LO    = OP_LO + 4;

	logic               room, take;
	logic [1:0]         push_cnt;
	logic [ENTRY_W-1:0] push0, push1, head;

	assign src_stall = !room;
	assign take      = src_valid && room;

	stt_front #(
		.COLUMN_BITS (COLUMN_BITS),
		.LINE_BITS   (LINE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.action    (action),
		.char_code (char_code),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1)
	);

	stt_rq #(
		.W (ENTRY_W)
	) u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.head      (head)
	);

	assign last_of_run   = head[0];
	assign end_column    = head[S_LO-1:E_LO];
	assign start_column  = head[L_LO-1:S_LO];
	assign line_number   = head[OP_LO-1:L_LO];
	assign operator_code = head[K_LO-1:OP_LO];
	assign token_kind    = head[ENTRY_W-2:K_LO];
	assign status        = head[ENTRY_W-1];

endmodule
`default_nettype wire

// ===== hdl/stt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: classifies each character, keeps mode and position
// counters and produces zero, one or two result entries per transaction.
// ----------------------------------------------------------------------------
module stt_front #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16,
	parameter int ENTRY_W     = 11 + LINE_BITS + 2 * COLUMN_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic               action,
	input  wire logic [7:0]         char_code,
	output logic      [1:0]         push_cnt,
	output logic      [ENTRY_W-1:0] push0,
	output logic      [ENTRY_W-1:0] push1
);

	typedef struct packed {
		logic                   st;
		logic [4:0]             kind;
		logic [3:0]             op;
		logic [COLUMN_BITS-1:0] s;
		logic [COLUMN_BITS-1:0] e;
	} res_t;

	stt_pkg::mode_t         mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [COLUMN_BITS-1:0] start_q, start_d;
	logic [39:0]            win_q, win_d;
	logic [2:0]             wlen_q, wlen_d;

	logic [COLUMN_BITS-1:0] col_nx, start_nx;
	logic [LINE_BITS-1:0]   line_nx;
	res_t                   fl, res0, res1;
	logic                   fl_vld, done;
	logic [1:0]             n;
	stt_pkg::sign_t         sg;

	assign col_nx   = (col_q == '1) ? col_q : col_q + 1'b1;
	assign start_nx = (start_q == '1) ? start_q : start_q + 1'b1;
	assign line_nx  = (line_q == '1) ? line_q : line_q + 1'b1;
	assign sg       = stt_pkg::sign_of(char_code);

	always_comb begin
		// pending token as it would be flushed at the current column
		fl_vld = 1'b1;
		fl     = '{st: stt_pkg::ST_TOKEN, kind: stt_pkg::KIND_NUM, op: stt_pkg::OP_NONE,
		           s: start_q, e: col_q};
		unique case (mode_q)
			stt_pkg::MODE_IDENT: fl.kind = stt_pkg::word_kind(win_q, wlen_q);
			stt_pkg::MODE_NUM:   fl.kind = stt_pkg::KIND_NUM;
			stt_pkg::MODE_MINUS: begin
				fl.kind = stt_pkg::KIND_BINOP;
				fl.op   = stt_pkg::OP_MINUS;
			end
			stt_pkg::MODE_EQ:    fl.kind = stt_pkg::KIND_ASSIGN;
			stt_pkg::MODE_BANG: begin
				fl.st = stt_pkg::ST_ERROR;
				fl.e  = start_nx;
			end
			default: fl_vld = 1'b0;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;
		start_d = start_q;
		win_d   = win_q;
		wlen_d  = wlen_q;
		n       = 2'd0;
		done    = 1'b0;
		res0    = fl;
		res1    = fl;
		if (take) begin
			if (action == stt_pkg::ACT_END) begin
				n       = fl_vld ? 2'd1 : 2'd0;
				mode_d  = stt_pkg::MODE_IDLE;
				line_d  = LINE_BITS'(1);
				col_d   = '0;
				start_d = '0;
				win_d   = '0;
				wlen_d  = '0;
			end else if (mode_q == stt_pkg::MODE_ERROR) begin
				// everything is dropped until end of text
			end else if (char_code == stt_pkg::CH_NL) begin
				n      = fl_vld ? 2'd1 : 2'd0;
				mode_d = (mode_q == stt_pkg::MODE_BANG) ? stt_pkg::MODE_ERROR
				                                       : stt_pkg::MODE_IDLE;
				line_d = line_nx;
				col_d  = '0;
			end else begin
				col_d = col_nx;
				unique case (mode_q)
					stt_pkg::MODE_COMMENT: done = 1'b1;
					stt_pkg::MODE_IDENT: begin
						if (stt_pkg::is_letter(char_code) || stt_pkg::is_digit(char_code)) begin
							win_d  = {win_q[31:0], char_code};
							wlen_d = (wlen_q < stt_pkg::WLEN_MAX) ? wlen_q + 3'd1 : wlen_q;
							done   = 1'b1;
						end
					end
					stt_pkg::MODE_NUM: done = stt_pkg::is_digit(char_code);
					stt_pkg::MODE_MINUS: begin
						if (char_code == stt_pkg::CH_GREATER) begin
							res0 = '{st: stt_pkg::ST_TOKEN, kind: stt_pkg::KIND_ARROW,
							         op: stt_pkg::OP_NONE, s: start_q, e: col_nx};
							n    = 2'd1;
							done = 1'b1;
						end
					end
					stt_pkg::MODE_EQ: begin
						if (char_code == stt_pkg::CH_EQUAL) begin
							res0 = '{st: stt_pkg::ST_TOKEN, kind: stt_pkg::KIND_BINOP,
							         op: stt_pkg::OP_EQ, s: start_q, e: col_nx};
							n    = 2'd1;
							done = 1'b1;
						end
					end
					stt_pkg::MODE_BANG: begin
						if (char_code == stt_pkg::CH_EQUAL) begin
							res0 = '{st: stt_pkg::ST_TOKEN, kind: stt_pkg::KIND_BINOP,
							         op: stt_pkg::OP_NE, s: start_q, e: col_nx};
							n    = 2'd1;
							done = 1'b1;
						end
					end
					default: done = 1'b0;
				endcase
				if (done) begin
					if (n != 2'd0) mode_d = stt_pkg::MODE_IDLE;
				end else begin
					n = fl_vld ? 2'd1 : 2'd0;
					if (mode_q == stt_pkg::MODE_BANG) begin
						mode_d = stt_pkg::MODE_ERROR;
					end else begin
						mode_d  = stt_pkg::MODE_IDLE;
						start_d = col_q;
						if (stt_pkg::is_blank(char_code)) begin
							mode_d = stt_pkg::MODE_IDLE;
						end else if (stt_pkg::is_letter(char_code)) begin
							mode_d = stt_pkg::MODE_IDENT;
							win_d  = {32'd0, char_code};
							wlen_d = 3'd1;
						end else if (stt_pkg::is_digit(char_code)) begin
							mode_d = stt_pkg::MODE_NUM;
						end else if (char_code == stt_pkg::CH_HASH) begin
							mode_d = stt_pkg::MODE_COMMENT;
						end else if (char_code == stt_pkg::CH_MINUS) begin
							mode_d = stt_pkg::MODE_MINUS;
						end else if (char_code == stt_pkg::CH_EQUAL) begin
							mode_d = stt_pkg::MODE_EQ;
						end else if (char_code == stt_pkg::CH_BANG) begin
							mode_d = stt_pkg::MODE_BANG;
						end else begin
							// complete sign or unknown byte, after any flushed token
							res1 = '{st: !sg.hit, kind: sg.kind, op: sg.op, s: col_q, e: col_nx};
							if (fl_vld) begin
								n = 2'd2;
							end else begin
								res0 = res1;
								n    = 2'd1;
							end
							mode_d = sg.hit ? stt_pkg::MODE_IDLE : stt_pkg::MODE_ERROR;
						end
					end
				end
			end
		end
	end

	assign push_cnt = n;
	assign push0 = {res0.st, res0.kind, res0.op, line_q, res0.s, res0.e, (n == 2'd1)};
	assign push1 = {res1.st, res1.kind, res1.op, line_q, res1.s, res1.e, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::MODE_IDLE;
			line_q  <= LINE_BITS'(1);
			col_q   <= '0;
			start_q <= '0;
			win_q   <= '0;
			wlen_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			start_q <= start_d;
			win_q   <= win_d;
			wlen_q  <= wlen_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/stt_rq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stt_rq
// Result queue between scanner and output port: takes up to two entries per
// cycle, hands out one per transaction from a registered head.
// ----------------------------------------------------------------------------
module stt_rq #(
	parameter int W = 54
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   push_cnt,
	input  wire logic [W-1:0] push0,
	input  wire logic [W-1:0] push1,
	output logic              room,
	output logic              tok_valid,
	input  wire logic         tok_stall,
	output logic      [W-1:0] head
);

	logic [W-1:0]                  mem_q [stt_pkg::RQ_DEPTH];
	logic [stt_pkg::RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [stt_pkg::RQ_CNT_W-1:0] cnt_q;
	logic                          pop;

	assign tok_valid = (cnt_q != '0);
	assign pop       = tok_valid && !tok_stall;
	assign head      = mem_q[rd_ptr_q];
	// two free slots needed, a character may cause two results
	assign room      = (cnt_q <= stt_pkg::RQ_CNT_W'(stt_pkg::RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_ptr_q + stt_pkg::RQ_PTR_W'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stt_pkg::RQ_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + stt_pkg::RQ_PTR_W'(pop);
			cnt_q    <= cnt_q + stt_pkg::RQ_CNT_W'(push_cnt) - stt_pkg::RQ_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/stt_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stt_chk
// Port-level checks for the source text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module stt_chk #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   tok_valid,
	input wire logic                   tok_stall,
	input wire logic                   status,
	input wire logic [4:0]             token_kind,
	input wire logic [3:0]             operator_code,
	input wire logic [LINE_BITS-1:0]   line_number,
	input wire logic [COLUMN_BITS-1:0] start_column,
	input wire logic [COLUMN_BITS-1:0] end_column,
	input wire logic                   last_of_run
);

	// a stalled result stays put
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind) && $stable(start_column)
		&& $stable(end_column) && $stable(line_number) && $stable(last_of_run))
		else $error("tok transaction changed while stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && status == stt_pkg::ST_ERROR |->
		token_kind == stt_pkg::KIND_NUM && operator_code == stt_pkg::OP_NONE)
		else $error("error result carries a kind or operator");

	// operator code present exactly on binops
	a_op_binop: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && status == stt_pkg::ST_TOKEN |->
		((token_kind == stt_pkg::KIND_BINOP) == (operator_code != stt_pkg::OP_NONE)))
		else $error("operator code does not match kind");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> token_kind <= stt_pkg::KIND_CCND && operator_code <= stt_pkg::OP_PIPE)
		else $error("kind or operator out of range");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> line_number != '0)
		else $error("line number is zero");

endmodule

bind source_text_tokenizer_unit stt_chk #(
	.COLUMN_BITS (COLUMN_BITS),
	.LINE_BITS   (LINE_BITS)
) u_stt_chk (.*);
`default_nettype wire

// ===== bench/source_text_tokenizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_tb
// Self-checking bench: random source text is streamed into the tokenizer and
// every token or error report is compared field by field with a local
// prediction of the scanner, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_tb;

	localparam int COLUMN_BITS   = 12;
	localparam int LINE_BITS     = 16;
	localparam int TEXT_ITEMS    = 1600;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic                   st;
		logic [4:0]             kind;
		logic [3:0]             op;
		logic [LINE_BITS-1:0]   line_no;
		logic [COLUMN_BITS-1:0] col_lo;
		logic [COLUMN_BITS-1:0] col_hi;
		logic                   last;
	} token_t;

	class token_scoreboard;
		token_t                 pending[$];
		stt_pkg::mode_t         mode;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [COLUMN_BITS-1:0] tstart;
		logic [39:0]            window;
		logic [2:0]             wlen;
		int errors, items, checked, err_reports, keywords, doubles, max_line, max_col;

		function void clear_state();
			mode   = stt_pkg::MODE_IDLE;
			line   = LINE_BITS'(1);
			col    = '0;
			tstart = '0;
			window = '0;
			wlen   = '0;
		endfunction

		function logic [COLUMN_BITS-1:0] col_bump(logic [COLUMN_BITS-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void emit(logic st, logic [4:0] kind, logic [3:0] op,
				logic [COLUMN_BITS-1:0] s, logic [COLUMN_BITS-1:0] e);
			token_t t;
			t = {st, kind, op, line, s, e, 1'b0};
			pending.insert(pending.size(), t);
		endfunction

		function logic [4:0] classify_word();
			logic [4:0] k;
			k = stt_pkg::KIND_IDENT;
			case (wlen)
				3'd2: begin
					if (window == stt_pkg::KW_FN) k = stt_pkg::KIND_FN;
					else if (window == stt_pkg::KW_IF) k = stt_pkg::KIND_IF;
				end
				3'd3: begin
					if (window == stt_pkg::KW_MUT) k = stt_pkg::KIND_MUT;
				end
				3'd4: begin
					if (window == stt_pkg::KW_ELSE) k = stt_pkg::KIND_ELSE;
					else if (window == stt_pkg::KW_ELIF) k = stt_pkg::KIND_ELIF;
					else if (window == stt_pkg::KW_CCND) k = stt_pkg::KIND_CCND;
				end
				default: k = stt_pkg::KIND_IDENT;
			endcase
			return k;
		endfunction

		function logic letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function logic digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		// close whatever token is open, ending at the current column
		function void flush_token();
			case (mode)
				stt_pkg::MODE_IDENT:
					emit(stt_pkg::ST_TOKEN, classify_word(), stt_pkg::OP_NONE, tstart, col);
				stt_pkg::MODE_NUM:
					emit(stt_pkg::ST_TOKEN, stt_pkg::KIND_NUM, stt_pkg::OP_NONE, tstart, col);
				stt_pkg::MODE_MINUS:
					emit(stt_pkg::ST_TOKEN, stt_pkg::KIND_BINOP, stt_pkg::OP_MINUS, tstart, col);
				stt_pkg::MODE_EQ:
					emit(stt_pkg::ST_TOKEN, stt_pkg::KIND_ASSIGN, stt_pkg::OP_NONE, tstart, col);
				stt_pkg::MODE_BANG: begin
					// kind reads zero on error reports
					emit(stt_pkg::ST_ERROR, stt_pkg::KIND_NUM, stt_pkg::OP_NONE, tstart,
						col_bump(tstart));
					mode = stt_pkg::MODE_ERROR;
					return;
				end
				default: return;
			endcase
			mode = stt_pkg::MODE_IDLE;
		endfunction

		function void begin_char(logic [7:0] c);
			logic [4:0] kind;
			logic [3:0] op;
			logic       hit;
			tstart = col;
			if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_CR) return;
			if (letter(c)) begin
				mode   = stt_pkg::MODE_IDENT;
				window = {32'h0, c};
				wlen   = 3'd1;
				return;
			end
			if (digit(c)) begin
				mode = stt_pkg::MODE_NUM;
				return;
			end
			hit  = 1'b1;
			kind = stt_pkg::KIND_BINOP;
			op   = stt_pkg::OP_NONE;
			case (c)
				stt_pkg::CH_HASH:  mode = stt_pkg::MODE_COMMENT;
				stt_pkg::CH_MINUS: mode = stt_pkg::MODE_MINUS;
				stt_pkg::CH_EQUAL: mode = stt_pkg::MODE_EQ;
				stt_pkg::CH_BANG:  mode = stt_pkg::MODE_BANG;
				";": kind = stt_pkg::KIND_SEMI;
				"(": kind = stt_pkg::KIND_LPAREN;
				")": kind = stt_pkg::KIND_RPAREN;
				"{": kind = stt_pkg::KIND_LBRACE;
				"}": kind = stt_pkg::KIND_RBRACE;
				",": kind = stt_pkg::KIND_COMMA;
				"+": op = stt_pkg::OP_PLUS;
				"*": op = stt_pkg::OP_MUL;
				"/": op = stt_pkg::OP_DIV;
				".": op = stt_pkg::OP_DOT;
				"|": op = stt_pkg::OP_PIPE;
				default: hit = 1'b0;
			endcase
			if (mode != stt_pkg::MODE_IDLE) return;
			if (!hit) begin
				emit(stt_pkg::ST_ERROR, stt_pkg::KIND_NUM, stt_pkg::OP_NONE, col, col_bump(col));
				mode = stt_pkg::MODE_ERROR;
			end else begin
				emit(stt_pkg::ST_TOKEN, kind, op, col, col_bump(col));
			end
		endfunction

		function void note_input(logic act, logic [7:0] c);
			int n_before;
			logic [COLUMN_BITS-1:0] nx;
			logic done;
			n_before = pending.size();
			items++;
			if (act == stt_pkg::ACT_END) begin
				flush_token();
				clear_state();
			end else if (mode == stt_pkg::MODE_ERROR) begin
				// swallowed until end of text
			end else if (c == stt_pkg::CH_NL) begin
				if (mode == stt_pkg::MODE_COMMENT) mode = stt_pkg::MODE_IDLE;
				flush_token();
				line = (&line) ? line : line + 1'b1;
				col  = '0;
			end else begin
				nx   = col_bump(col);
				done = 1'b0;
				case (mode)
					stt_pkg::MODE_COMMENT: done = 1'b1;
					stt_pkg::MODE_IDENT: begin
						if (letter(c) || digit(c)) begin
							window = {window[31:0], c};
							if (wlen < stt_pkg::WLEN_MAX) wlen++;
							done = 1'b1;
						end
					end
					stt_pkg::MODE_NUM: done = digit(c);
					stt_pkg::MODE_MINUS: begin
						if (c == stt_pkg::CH_GREATER) begin
							emit(stt_pkg::ST_TOKEN, stt_pkg::KIND_ARROW, stt_pkg::OP_NONE,
								tstart, nx);
							mode = stt_pkg::MODE_IDLE;
							done = 1'b1;
						end
					end
					stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
						if (c == stt_pkg::CH_EQUAL) begin
							emit(stt_pkg::ST_TOKEN, stt_pkg::KIND_BINOP,
								(mode == stt_pkg::MODE_EQ) ? stt_pkg::OP_EQ : stt_pkg::OP_NE,
								tstart, nx);
							mode = stt_pkg::MODE_IDLE;
							done = 1'b1;
						end
					end
					default: ;
				endcase
				if (!done) begin
					flush_token();
					if (mode != stt_pkg::MODE_ERROR) begin_char(c);
				end
				col = nx;
			end
			if (pending.size() - n_before == 2) doubles++;
			if (pending.size() > n_before) pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: token %0d %s mismatch, expected %0d, got %0d",
					$time, checked, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(token_t got);
			token_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected token st=%0d kind=%0d op=%0d line=%0d cols=%0d..%0d",
					$time, got.st, got.kind, got.op, got.line_no, got.col_lo, got.col_hi);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("status", 32'(want.st), 32'(got.st));
			compare_field("token_kind", 32'(want.kind), 32'(got.kind));
			compare_field("operator_code", 32'(want.op), 32'(got.op));
			compare_field("line_number", 32'(want.line_no), 32'(got.line_no));
			compare_field("start_column", 32'(want.col_lo), 32'(got.col_lo));
			compare_field("end_column", 32'(want.col_hi), 32'(got.col_hi));
			compare_field("last_of_run", 32'(want.last), 32'(got.last));
			checked++;
			if (got.st == stt_pkg::ST_ERROR) err_reports++;
			else if (got.kind >= stt_pkg::KIND_FN) keywords++;
			if (int'(got.line_no) > max_line) max_line = int'(got.line_no);
			if (int'(got.col_lo) > max_col) max_col = int'(got.col_lo);
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   src_valid = 1'b0;
	logic                   action    = stt_pkg::ACT_CHAR;
	logic [7:0]             char_code = 8'h00;
	logic                   tok_stall = 1'b0;
	logic                   src_stall;
	logic                   tok_valid;
	logic                   status;
	logic [4:0]             token_kind;
	logic [3:0]             operator_code;
	logic [LINE_BITS-1:0]   line_number;
	logic [COLUMN_BITS-1:0] start_column;
	logic [COLUMN_BITS-1:0] end_column;
	logic                   last_of_run;

	token_scoreboard sb;
	token_t          tok_seen;
	int              send_idle  = 0;
	int              recv_stall = 0;
	int              pushed     = 0;
	int              ignored    = 0;
	int              cycles     = 0;
	int              idle_plan[4]  = '{0, 71, 0, 31};
	int              stall_plan[4] = '{0, 0, 71, 31};
	string           keyword_text[6] = '{"fn", "mut", "if", "else", "elif", "ccnd"};
	string           word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	string           sign_chars = ";(){}+*/.|,=-";
	string           blank_chars = " \t\r";
	string           odd_chars = "@$%^&?<>:'\"\\`~[]";

	source_text_tokenizer_unit #(
		.COLUMN_BITS(COLUMN_BITS),
		.LINE_BITS  (LINE_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.action       (action),
		.char_code    (char_code),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.status       (status),
		.token_kind   (token_kind),
		.operator_code(operator_code),
		.line_number  (line_number),
		.start_column (start_column),
		.end_column   (end_column),
		.last_of_run  (last_of_run)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		tok_stall <= ($urandom_range(99) < recv_stall);
	end

	// results are checked before the input of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				tok_seen = {status, token_kind, operator_code, line_number,
					start_column, end_column, last_of_run};
				sb.check_result(tok_seen);
			end
			if (src_valid && !src_stall) sb.note_input(action, char_code);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d tokens outstanding", $time, sb.pending.size());
			$display("source_text_tokenizer_unit regression: fail");
			$finish;
		end
	end

	task automatic push(input logic act, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		action    <= act;
		char_code <= ch;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		pushed++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push(stt_pkg::ACT_CHAR, s[i]);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] any_word_char();
		return word_chars[$urandom_range(word_chars.len() - 1)];
	endfunction

	function automatic logic [7:0] odd_byte();
		logic [7:0] c;
		if ($urandom_range(1)) return odd_chars[$urandom_range(odd_chars.len() - 1)];
		c = 8'($urandom_range(31));
		if (c == stt_pkg::CH_TAB || c == stt_pkg::CH_NL || c == stt_pkg::CH_CR) c = 8'd127;
		return c;
	endfunction

	// one well-formed piece of text, or now and then an error and its tail
	task automatic random_snippet();
		int         pick;
		int         n;
		string      kw;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 18) begin
			n = $urandom_range(52);
			push(stt_pkg::ACT_CHAR, word_chars[(n == 52) ? 62 : n]);
			repeat ($urandom_range(7)) push(stt_pkg::ACT_CHAR, any_word_char());
		end else if (pick < 27) begin
			push_text(keyword_text[$urandom_range(5)]);
		end else if (pick < 31) begin
			// near misses of keywords
			kw = keyword_text[$urandom_range(5)];
			case ($urandom_range(2))
				0: begin
					push_text(kw);
					push(stt_pkg::ACT_CHAR, any_word_char());
				end
				1: begin
					push(stt_pkg::ACT_CHAR, kw[0] - 8'd32);
					push_text(kw.substr(1, kw.len() - 1));
				end
				default: begin
					push(stt_pkg::ACT_CHAR, "_");
					push_text(kw);
				end
			endcase
		end else if (pick < 41) begin
			repeat ($urandom_range(5, 1)) push(stt_pkg::ACT_CHAR, 8'("0" + $urandom_range(9)));
		end else if (pick < 59) begin
			push(stt_pkg::ACT_CHAR, sign_chars[$urandom_range(sign_chars.len() - 1)]);
		end else if (pick < 67) begin
			case ($urandom_range(2))
				0: push_text("->");
				1: push_text("==");
				default: push_text("!=");
			endcase
		end else if (pick < 80) begin
			repeat ($urandom_range(3, 1)) push(stt_pkg::ACT_CHAR, blank_chars[$urandom_range(2)]);
		end else if (pick < 86) begin
			push(stt_pkg::ACT_CHAR, stt_pkg::CH_NL);
		end else if (pick < 90) begin
			push(stt_pkg::ACT_CHAR, stt_pkg::CH_HASH);
			repeat ($urandom_range(6)) begin
				c = 8'($urandom_range(255));
				push(stt_pkg::ACT_CHAR, (c == stt_pkg::CH_NL) ? stt_pkg::CH_HASH : c);
			end
			push(stt_pkg::ACT_CHAR, stt_pkg::CH_NL);
		end else if (pick < 94) begin
			push(stt_pkg::ACT_END, 8'($urandom_range(255)));
		end else begin
			case ($urandom_range(2))
				0: begin
					// bang before a word char, a newline, or the random tail and end of text
					push(stt_pkg::ACT_CHAR, stt_pkg::CH_BANG);
					case ($urandom_range(2))
						0: push(stt_pkg::ACT_CHAR, any_word_char());
						1: push(stt_pkg::ACT_CHAR, stt_pkg::CH_NL);
						default: ;
					endcase
				end
				1: push(stt_pkg::ACT_CHAR, 8'($urandom_range(255, 128)));
				default: push(stt_pkg::ACT_CHAR, odd_byte());
			endcase
			repeat ($urandom_range(4)) begin
				push(stt_pkg::ACT_CHAR, 8'($urandom_range(255)));
				ignored++;
			end
			push(stt_pkg::ACT_END, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int goal;
		sb = new;
		sb.clear_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pairs, two tokens per character, lone bang cases, extreme bytes
		push_text("ab;-x==1!=2\n");
		push(stt_pkg::ACT_CHAR, stt_pkg::CH_BANG);
		push(stt_pkg::ACT_END, 8'hFF);
		push_text("!\n");
		push(stt_pkg::ACT_CHAR, 8'hFF);
		push(stt_pkg::ACT_END, 8'h00);
		push(stt_pkg::ACT_CHAR, 8'h00);
		push(stt_pkg::ACT_END, 8'h00);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = idle_plan[ph];
			recv_stall = stall_plan[ph];
			goal = pushed - ignored + TEXT_ITEMS / 4;
			while (pushed - ignored < goal) random_snippet();
			push(stt_pkg::ACT_END, 8'h00);
			// sender holds off until every pending token is out
			drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d transactions in, %0d tokens checked: %0d error reports,",
			sb.items, sb.checked, sb.err_reports);
		$display("%0d keywords, %0d double steps, highest line %0d, highest column %0d",
			sb.keywords, sb.doubles, sb.max_line, sb.max_col);
		if (sb.errors == 0) begin
			$display("source_text_tokenizer_unit regression: pass");
		end else begin
			$display("source_text_tokenizer_unit regression: fail");
		end
		$finish;
	end

endmodule
